// ===== src/pdl_pkg.sv =====
// ----------------------------------------------------------------------------
// pdl_pkg: shared types, sizes and microcode for the prime divisor lister
// Holds the datapath sizes, the control word layout, the step addresses
// and the read-only control program.
// ----------------------------------------------------------------------------
package pdl_pkg;

  // Datapath sizes
  localparam int WIDTH       = 32;
  localparam int MAX_PRIMES  = 16;
  localparam int PRIME_DEPTH = MAX_PRIMES - 1;
  localparam int CNT_W       = $clog2(MAX_PRIMES + 1);
  localparam int IDX_W       = $clog2(PRIME_DEPTH);
  localparam int DCNT_W      = $clog2(WIDTH + 1);
  localparam int FIRST_TRIAL = 2;

  // Microcode program size
  localparam int NUM_STEPS = 17;
  localparam int PC_W      = $clog2(NUM_STEPS);

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_ADD_TRIAL,
    OP_REST_Q,
    OP_INC_TRIAL,
    OP_ADD_REST,
    OP_EMIT_ECHO,
    OP_EMIT_PRIME
  } op_t;

  // Jump conditions; C_NEXT never jumps
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_BELOW_TWO,
    C_DIV_BUSY,
    C_TRIAL_GT_Q,
    C_REM_NZ,
    C_OUT_FULL,
    C_OUT_DONE
  } cond_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  // Step addresses
  localparam pc_t S_IDLE       = PC_W'(0);
  localparam pc_t S_CHK_LOW    = PC_W'(1);
  localparam pc_t S_TRY_DIV    = PC_W'(2);
  localparam pc_t S_TRY_STEP   = PC_W'(3);
  localparam pc_t S_TRY_TEST   = PC_W'(4);
  localparam pc_t S_TRY_REM    = PC_W'(5);
  localparam pc_t S_ADD        = PC_W'(6);
  localparam pc_t S_RED_DIV    = PC_W'(7);
  localparam pc_t S_RED_STEP   = PC_W'(8);
  localparam pc_t S_RED_REM    = PC_W'(9);
  localparam pc_t S_RED_REST   = PC_W'(10);
  localparam pc_t S_NEXT_TRIAL = PC_W'(11);
  localparam pc_t S_EXTRA      = PC_W'(12);
  localparam pc_t S_ECHO       = PC_W'(13);
  localparam pc_t S_MORE       = PC_W'(14);
  localparam pc_t S_PRIME      = PC_W'(15);
  localparam pc_t S_LOOP       = PC_W'(16);

  function automatic ctrl_t cw(op_t o, cond_t c, pc_t t);
    ctrl_t w;
    w.op     = o;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // Control program: jump to target when the condition holds, else step on
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    case (pc)
      S_IDLE:       w = cw(OP_LOAD,       C_NO_INPUT,   S_IDLE);
      S_CHK_LOW:    w = cw(OP_NONE,       C_BELOW_TWO,  S_ECHO);
      S_TRY_DIV:    w = cw(OP_DIV_START,  C_NEXT,       S_IDLE);
      S_TRY_STEP:   w = cw(OP_DIV_STEP,   C_DIV_BUSY,   S_TRY_STEP);
      S_TRY_TEST:   w = cw(OP_NONE,       C_TRIAL_GT_Q, S_EXTRA);
      S_TRY_REM:    w = cw(OP_NONE,       C_REM_NZ,     S_NEXT_TRIAL);
      S_ADD:        w = cw(OP_ADD_TRIAL,  C_NEXT,       S_IDLE);
      S_RED_DIV:    w = cw(OP_DIV_START,  C_NEXT,       S_IDLE);
      S_RED_STEP:   w = cw(OP_DIV_STEP,   C_DIV_BUSY,   S_RED_STEP);
      S_RED_REM:    w = cw(OP_NONE,       C_REM_NZ,     S_NEXT_TRIAL);
      S_RED_REST:   w = cw(OP_REST_Q,     C_ALWAYS,     S_RED_DIV);
      S_NEXT_TRIAL: w = cw(OP_INC_TRIAL,  C_ALWAYS,     S_TRY_DIV);
      S_EXTRA:      w = cw(OP_ADD_REST,   C_NEXT,       S_IDLE);
      S_ECHO:       w = cw(OP_EMIT_ECHO,  C_OUT_FULL,   S_ECHO);
      S_MORE:       w = cw(OP_NONE,       C_OUT_DONE,   S_IDLE);
      S_PRIME:      w = cw(OP_EMIT_PRIME, C_OUT_FULL,   S_PRIME);
      S_LOOP:       w = cw(OP_NONE,       C_ALWAYS,     S_MORE);
      default:      w = cw(OP_NONE,       C_ALWAYS,     S_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ===== src/prime_divisor_lister.sv =====
// Each division runs in the shared bit-serial divider; a trial value that does
// not divide costs one division, and each division that takes out a prime
// factor costs one more. Trial values run up to the square root of what
// remains, then the echo and each prime divisor are emitted in turn.
// One item at a time: the next item is taken only after the last result is
// loaded and the sequencer is back in idle. Reset (synchronous, rst_n low) idles the sequencer.
// ----------------------------------------------------------------------------
// prime_divisor_lister: distinct prime divisors by trial division
// A microcoded sequencer steps a bit-serial restoring divider over trial
// values, stores the primes found, then emits the echo and the primes.
// ----------------------------------------------------------------------------
module prime_divisor_lister (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pdl_pkg::WIDTH-1:0]  in_number,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pdl_pkg::WIDTH-1:0]  out_value,
  output logic                       out_is_divisor,
  output logic                       out_below_two,
  output logic                       out_last
);
  import pdl_pkg::*;

  // Sequencer
  pc_t   pc_r, pc_nxt;
  ctrl_t ctrl;
  logic  jump;

  // Datapath registers
  logic [WIDTH-1:0]  number_r;
  logic [WIDTH-1:0]  rest_r;
  logic [WIDTH-1:0]  trial_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  out_idx_r;
  logic [CNT_W-1:0]  out_idx_nxt;
  logic [WIDTH-1:0]  primes_r [0:PRIME_DEPTH-1];

  // Divider registers
  logic [WIDTH-1:0]  div_q_r;
  logic [WIDTH-1:0]  div_rem_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic [WIDTH:0]    div_part;
  logic [WIDTH:0]    div_diff;
  logic              div_fit;

  // Output register
  logic              out_valid_r;
  logic [WIDTH-1:0]  out_value_r;
  logic              out_is_divisor_r;
  logic              out_below_two_r;
  logic              out_last_r;
  logic              out_full;

  logic              below_two;
  logic              has_room;
  logic              rest_counts;

  assign ctrl        = ucode(pc_r);
  assign below_two   = (number_r < WIDTH'(FIRST_TRIAL));
  assign has_room    = (count_r < CNT_W'(PRIME_DEPTH));
  assign rest_counts = (rest_r > WIDTH'(1)) && (rest_r != number_r);
  assign out_full    = out_valid_r && out_stall;
  assign out_idx_nxt = out_idx_r + CNT_W'(1);

  // Restoring divider step: shift in one dividend bit, subtract if it fits
  assign div_part = {div_rem_r, div_q_r[WIDTH-1]};
  assign div_diff = div_part - {1'b0, trial_r};
  assign div_fit  = !div_diff[WIDTH];

  // Evaluate the jump condition of the current step
  always_comb begin
    case (ctrl.cond)
      C_NEXT:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_INPUT:   jump = !in_valid;
      C_BELOW_TWO:  jump = below_two;
      C_DIV_BUSY:   jump = (div_cnt_r != DCNT_W'(1));
      C_TRIAL_GT_Q: jump = (trial_r > div_q_r);
      C_REM_NZ:     jump = (div_rem_r != '0);
      C_OUT_FULL:   jump = out_full;
      C_OUT_DONE:   jump = (out_idx_r == count_r);
      default:      jump = 1'b1;
    endcase
    pc_nxt = jump ? ctrl.target : pc_r + PC_W'(1);
  end

  assign in_stall = (pc_r != S_IDLE);

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Control counters of the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_idx_r <= '0;
      div_cnt_r <= '0;
    end else begin
      case (ctrl.op)
        OP_LOAD: begin
          if (in_valid) begin
            count_r   <= '0;
            out_idx_r <= '0;
          end
        end
        OP_DIV_START:  div_cnt_r <= DCNT_W'(WIDTH);
        OP_DIV_STEP:   div_cnt_r <= div_cnt_r - DCNT_W'(1);
        OP_ADD_TRIAL: begin
          if (has_room) begin
            count_r <= count_r + CNT_W'(1);
          end
        end
        OP_ADD_REST: begin
          if (has_room && rest_counts) begin
            count_r <= count_r + CNT_W'(1);
          end
        end
        OP_EMIT_PRIME: begin
          if (!out_full) begin
            out_idx_r <= out_idx_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath: operand, trial value, divider and prime list
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (in_valid) begin
          number_r <= in_number;
          rest_r   <= in_number;
          trial_r  <= WIDTH'(FIRST_TRIAL);
        end
      end
      OP_DIV_START: begin
        div_q_r   <= rest_r;
        div_rem_r <= '0;
      end
      OP_DIV_STEP: begin
        div_q_r   <= {div_q_r[WIDTH-2:0], div_fit};
        div_rem_r <= div_fit ? div_diff[WIDTH-1:0] : div_part[WIDTH-1:0];
      end
      OP_ADD_TRIAL: begin
        if (has_room) begin
          primes_r[count_r[IDX_W-1:0]] <= trial_r;
        end
        rest_r <= div_q_r;
      end
      OP_REST_Q:    rest_r  <= div_q_r;
      OP_INC_TRIAL: trial_r <= trial_r + WIDTH'(1);
      OP_ADD_REST: begin
        if (has_room && rest_counts) begin
          primes_r[count_r[IDX_W-1:0]] <= rest_r;
        end
      end
      default: ;
    endcase
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctrl.op == OP_EMIT_ECHO || ctrl.op == OP_EMIT_PRIME) && !out_full) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the item payload beside the valid flag
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT_ECHO && !out_full) begin
      out_value_r      <= number_r;
      out_is_divisor_r <= 1'b0;
      out_below_two_r  <= below_two;
      out_last_r       <= (count_r == '0);
    end else if (ctrl.op == OP_EMIT_PRIME && !out_full) begin
      out_value_r      <= primes_r[out_idx_r[IDX_W-1:0]];
      out_is_divisor_r <= 1'b1;
      out_below_two_r  <= 1'b0;
      out_last_r       <= (out_idx_nxt == count_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_is_divisor = out_is_divisor_r;
  assign out_below_two  = out_below_two_r;
  assign out_last       = out_last_r;

  // Checks on the sequencer and datapath
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(PRIME_DEPTH))
    else $error("prime count beyond list depth");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_idx_r <= count_r)
    else $error("emit index passed prime count");

  a_div_trial: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DIV_STEP) |-> (trial_r >= WIDTH'(FIRST_TRIAL)))
    else $error("division by a trial value below two");

  a_prime_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_divisor_r) |-> !out_below_two_r)
    else $error("prime result flagged below two");

  a_emit_held: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT_PRIME && out_full) |=> (pc_r == S_PRIME))
    else $error("prime emit left while output full");

endmodule
